// File: hdl/bic_pkg.sv
// ----------------------------------------------------------------------------
// bic_pkg
// shared types, codes and tables of the banked interrupt controller
// ----------------------------------------------------------------------------
package bic_pkg;

  typedef enum logic [2:0] {
    FUNC_SET_EN  = 3'd0,
    FUNC_CLR_EN  = 3'd1,
    FUNC_RD_EN   = 3'd2,
    FUNC_RD_PEND = 3'd3,
    FUNC_RD_NEXT = 3'd4
  } func_e;

  localparam logic [1:0] BANK_LOCAL = 2'd0;
  localparam logic [1:0] BANK_LOW   = 2'd1;
  localparam logic [1:0] BANK_HIGH  = 2'd2;

  localparam int unsigned SC_COUNT  = 11;
  localparam int unsigned SC1_COUNT = 5;

  // peripheral lines mirrored into the bank 0 pending word, bits 10 upward
  localparam logic [4:0] SC_LINE [SC_COUNT] = '{
    5'd7, 5'd9, 5'd10, 5'd18, 5'd19,
    5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd30
  };

  typedef struct packed {
    logic [7:0]  loc_en;
    logic [31:0] low_en;
    logic [31:0] high_en;
  } en_t;

  typedef struct packed {
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } pend_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  bank;
    logic [31:0] wdata;
  } req_t;

  // index of the lowest set bit, zero when none
  function automatic logic [4:0] low_bit_idx(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: hdl/banked_interrupt_controller.sv
// ----------------------------------------------------------------------------
// banked_interrupt_controller
// three-bank interrupt controller with shortcut bits, one access per transfer
// ----------------------------------------------------------------------------
// usage:
//   each slave-side transfer carries one register access (func, bank, wdata)
//   together with a sample of the 8 local and 64 peripheral raw lines
//   each access yields exactly one master-side transfer with the read data,
//   the next interrupt number and its valid flag
//   the access is held in an input register; the enables, pending words and
//   priority decode sit between it and the result register
//   the result register loads the decode of the held access once it can
//   advance, and the result transfer is driven from the result register
//   throughput: one access per cycle while the receiver takes each result,
//   set by the single enable update and decode path between the registers
//   the decode uses the enables from before the access; a write shows up
//   for the next access
//   reset clears all enables and empties both registers
//   when the receiver stalls the result register holds and the input
//   register keeps one more access before tready drops
// ----------------------------------------------------------------------------
module banked_interrupt_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // wdata[31:0], raw_local[39:32], raw_gpu_low[71:40], raw_gpu_high[103:72]
  input  logic [103:0] s_axis_tdata_i,
  // func[2:0], bank[4:3]
  input  logic [4:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rdata[31:0], irq_number[38:32], zero fill[39]
  output logic [39:0]  m_axis_tdata_o,
  // irq_valid[0]
  output logic         m_axis_tuser_o
);
  import bic_pkg::*;

  // input register
  logic        in_valid_q;
  req_t        req_q;
  logic [7:0]  raw_local_q;
  logic [31:0] raw_low_q, raw_high_q;

  // result register
  logic        out_valid_q;
  logic [31:0] rdata_q, rdata_d;
  logic [6:0]  irq_number_q;
  logic        irq_valid_q;

  logic        advance;   // result register can take a new value
  logic        fire;      // the held access is processed this cycle
  logic        s_accept;
  en_t         en;
  pend_t       pend;
  logic [6:0]  irq_number;
  logic        irq_valid;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q.func  <= s_axis_tuser_i[2:0];
      req_q.bank  <= s_axis_tuser_i[4:3];
      req_q.wdata <= s_axis_tdata_i[31:0];
      raw_local_q <= s_axis_tdata_i[39:32];
      raw_low_q   <= s_axis_tdata_i[71:40];
      raw_high_q  <= s_axis_tdata_i[103:72];
    end
  end

  bic_enables u_enables (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .en_o   (en)
  );

  bic_pending u_pending (
    .en_i           (en),
    .raw_local_i    (raw_local_q),
    .raw_gpu_low_i  (raw_low_q),
    .raw_gpu_high_i (raw_high_q),
    .pend_o         (pend),
    .irq_number_o   (irq_number),
    .irq_valid_o    (irq_valid)
  );

  // read data: enable or pending word of the addressed bank, zero otherwise
  always_comb begin
    rdata_d = '0;
    case (req_q.func)
      FUNC_RD_EN: begin
        case (req_q.bank)
          BANK_LOCAL: rdata_d = {24'b0, en.loc_en};
          BANK_LOW:   rdata_d = en.low_en;
          BANK_HIGH:  rdata_d = en.high_en;
          default:    rdata_d = '0;
        endcase
      end
      FUNC_RD_PEND: begin
        case (req_q.bank)
          BANK_LOCAL: rdata_d = pend.p0;
          BANK_LOW:   rdata_d = pend.p1;
          BANK_HIGH:  rdata_d = pend.p2;
          default:    rdata_d = '0;
        endcase
      end
      default: rdata_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q      <= rdata_d;
      irq_number_q <= irq_number;
      irq_valid_q  <= irq_valid;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, irq_number_q, rdata_q};
  assign m_axis_tuser_o  = irq_valid_q;

endmodule

// File: hdl/bic_enables.sv
// ----------------------------------------------------------------------------
// bic_enables
// enable registers of the three banks with set and clear access
// ----------------------------------------------------------------------------
module bic_enables (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  bic_pkg::req_t req_i,
  output bic_pkg::en_t  en_o
);
  import bic_pkg::*;

  en_t en_q, en_d;

  always_comb begin
    en_d = en_q;
    if (fire_i) begin
      case (req_i.func)
        FUNC_SET_EN: begin
          case (req_i.bank)
            BANK_LOCAL: en_d.loc_en  = en_q.loc_en | req_i.wdata[7:0];
            BANK_LOW:   en_d.low_en  = en_q.low_en | req_i.wdata;
            BANK_HIGH:  en_d.high_en = en_q.high_en | req_i.wdata;
            default: ;
          endcase
        end
        FUNC_CLR_EN: begin
          case (req_i.bank)
            BANK_LOCAL: en_d.loc_en  = en_q.loc_en & ~req_i.wdata[7:0];
            BANK_LOW:   en_d.low_en  = en_q.low_en & ~req_i.wdata;
            BANK_HIGH:  en_d.high_en = en_q.high_en & ~req_i.wdata;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else begin
      en_q <= en_d;
    end
  end

  assign en_o = en_q;

endmodule

// File: hdl/bic_pending.sv
// ----------------------------------------------------------------------------
// bic_pending
// pending words and priority decode of the next interrupt
// ----------------------------------------------------------------------------
module bic_pending (
  input  bic_pkg::en_t  en_i,
  input  logic [7:0]    raw_local_i,
  input  logic [31:0]   raw_gpu_low_i,
  input  logic [31:0]   raw_gpu_high_i,
  output bic_pkg::pend_t pend_o,
  output logic [6:0]    irq_number_o,
  output logic          irq_valid_o
);
  import bic_pkg::*;

  logic [31:0] p0, p1, p2;
  logic [4:0]  idx_loc, idx_sc1, idx_sc2, idx_p1, idx_p2;
  logic [3:0]  k1, k2;

  always_comb begin
    p1 = raw_gpu_low_i & en_i.low_en;
    p2 = raw_gpu_high_i & en_i.high_en;
    p0 = '0;
    p0[7:0] = raw_local_i & en_i.loc_en;
    p0[8]   = |p1;
    p0[9]   = |p2;
    for (int k = 0; k < SC_COUNT; k++) begin
      if (k < SC1_COUNT) begin
        p0[10+k] = p1[SC_LINE[k]];
      end else begin
        p0[10+k] = p2[SC_LINE[k]];
      end
    end
  end

  always_comb begin
    idx_loc = low_bit_idx({24'b0, p0[7:0]});
    idx_sc1 = low_bit_idx({27'b0, p0[14:10]});
    idx_sc2 = low_bit_idx({26'b0, p0[20:15]});
    idx_p1  = low_bit_idx(p1);
    idx_p2  = low_bit_idx(p2);
    k1      = idx_sc1[3:0];
    k2      = idx_sc2[3:0] + 4'(SC1_COUNT);

    irq_valid_o  = 1'b1;
    irq_number_o = '0;
    if (|p0[7:0]) begin
      irq_number_o = {2'b00, idx_loc};
    end else if (|p0[14:10]) begin
      irq_number_o = 7'd32 + {2'b00, SC_LINE[k1]};
    end else if (|p0[20:15]) begin
      irq_number_o = 7'd64 + {2'b00, SC_LINE[k2]};
    end else if (p0[8]) begin
      irq_number_o = 7'd32 + {2'b00, idx_p1};
    end else if (p0[9]) begin
      irq_number_o = 7'd64 + {2'b00, idx_p2};
    end else begin
      irq_valid_o = 1'b0;
    end
  end

  assign pend_o = '{p0: p0, p1: p1, p2: p2};

endmodule

// File: verif/banked_interrupt_controller_test.sv
// ----------------------------------------------------------------------------
// banked_interrupt_controller_test
// self-checking bench: streams register accesses with raw line samples into
// the controller, predicts every read word and next-interrupt decode from its
// own copy of the enables, and compares each result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module banked_interrupt_controller_test;
  import bic_pkg::*;

  // codes outside the package enum and bank map, still legal on the bus
  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;
  localparam logic [1:0] BANK_UNMAPPED   = 2'd3;

  // peripheral lines mirrored into bank 0 pending bits 10 and up
  localparam int unsigned N_SHORTCUT = 11;
  localparam int unsigned N_SC_LOW   = 5;
  localparam logic [4:0] SHORTCUT_LINE [N_SHORTCUT] = '{
    5'd7, 5'd9, 5'd10, 5'd18, 5'd19,
    5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd30
  };
  localparam logic [31:0] SC_LOW_LINES  = 32'h000C_0680;
  localparam logic [31:0] SC_HIGH_LINES = 32'h43E0_0000;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  bank;
    logic [31:0] wdata;
    logic [7:0]  raw_local;
    logic [31:0] raw_low;
    logic [31:0] raw_high;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [6:0]  irq_num;
    logic        irq_valid;
  } reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic [4:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;

  banked_interrupt_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  access_t     access_q[$];
  reply_t      pending_replies[$];
  int          src_idle_pct = 6;
  int          snk_stall_pct = 49;
  int          err_count = 0;
  bit          acc_fire = 1'b0;

  // predictor copy of the enable registers
  logic [7:0]  loc_en_m;
  logic [31:0] low_en_m;
  logic [31:0] high_en_m;

  task automatic flag_error(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int first_set(input logic [31:0] v);
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        return i;
      end
    end
    return 0;
  endfunction

  // one access: decode against the enables as they stand, then apply writes
  function automatic reply_t controller_step(input access_t a);
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
    reply_t      r;
    p1 = a.raw_low & low_en_m;
    p2 = a.raw_high & high_en_m;
    p0 = {24'd0, a.raw_local & loc_en_m};
    p0[8] = (p1 != '0);
    p0[9] = (p2 != '0);
    for (int k = 0; k < N_SHORTCUT; k++) begin
      p0[10 + k] = (k < N_SC_LOW) ? p1[SHORTCUT_LINE[k]] : p2[SHORTCUT_LINE[k]];
    end

    r = '0;
    r.irq_valid = 1'b1;
    if (p0[7:0] != '0) begin
      r.irq_num = 7'(first_set({24'd0, p0[7:0]}));
    end else if (p0[14:10] != '0) begin
      r.irq_num = 7'd32 + 7'(SHORTCUT_LINE[first_set({27'd0, p0[14:10]})]);
    end else if (p0[20:15] != '0) begin
      r.irq_num = 7'd64 + 7'(SHORTCUT_LINE[N_SC_LOW + first_set({26'd0, p0[20:15]})]);
    end else if (p0[8]) begin
      r.irq_num = 7'd32 + 7'(first_set(p1));
    end else if (p0[9]) begin
      r.irq_num = 7'd64 + 7'(first_set(p2));
    end else begin
      r.irq_valid = 1'b0;
    end

    case (a.func)
      FUNC_SET_EN: begin
        case (a.bank)
          BANK_LOCAL: loc_en_m  = loc_en_m | a.wdata[7:0];
          BANK_LOW:   low_en_m  = low_en_m | a.wdata;
          BANK_HIGH:  high_en_m = high_en_m | a.wdata;
          default: ;
        endcase
      end
      FUNC_CLR_EN: begin
        case (a.bank)
          BANK_LOCAL: loc_en_m  = loc_en_m & ~a.wdata[7:0];
          BANK_LOW:   low_en_m  = low_en_m & ~a.wdata;
          BANK_HIGH:  high_en_m = high_en_m & ~a.wdata;
          default: ;
        endcase
      end
      FUNC_RD_EN: begin
        case (a.bank)
          BANK_LOCAL: r.rdata = {24'd0, loc_en_m};
          BANK_LOW:   r.rdata = low_en_m;
          BANK_HIGH:  r.rdata = high_en_m;
          default: ;
        endcase
      end
      FUNC_RD_PEND: begin
        case (a.bank)
          BANK_LOCAL: r.rdata = p0;
          BANK_LOW:   r.rdata = p1;
          BANK_HIGH:  r.rdata = p2;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: new values at the falling edge once the previous transfer went
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || acc_fire) begin
        if (access_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          access_t a;
          a = access_q.pop_front();
          s_axis_tdata_i  <= {a.raw_high, a.raw_low, a.raw_local, a.wdata};
          s_axis_tuser_i  <= {a.bank, a.func};
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      acc_fire = 1'b0;
      m_axis_tready_i <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // monitor: predict on each accepted access, check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        access_t a;
        a.func      = s_axis_tuser_i[2:0];
        a.bank      = s_axis_tuser_i[4:3];
        a.wdata     = s_axis_tdata_i[31:0];
        a.raw_local = s_axis_tdata_i[39:32];
        a.raw_low   = s_axis_tdata_i[71:40];
        a.raw_high  = s_axis_tdata_i[103:72];
        pending_replies.push_back(controller_step(a));
        acc_fire = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_replies.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding, rdata %h",
                               m_axis_tdata_o[31:0]));
        end else begin
          reply_t want;
          want = pending_replies.pop_front();
          if (m_axis_tdata_o[31:0] !== want.rdata) begin
            flag_error($sformatf("rdata got %h want %h", m_axis_tdata_o[31:0], want.rdata));
          end
          if (m_axis_tdata_o[38:32] !== want.irq_num) begin
            flag_error($sformatf("irq_number got %0d want %0d",
                                 m_axis_tdata_o[38:32], want.irq_num));
          end
          if (m_axis_tuser_o !== want.irq_valid) begin
            flag_error($sformatf("irq_valid got %b want %b", m_axis_tuser_o, want.irq_valid));
          end
        end
      end
    end
  end

  task automatic push_access(input logic [2:0] func, input logic [1:0] bank,
                             input logic [31:0] wdata, input logic [7:0] loc,
                             input logic [31:0] low, input logic [31:0] high);
    access_t a;
    a = '{func: func, bank: bank, wdata: wdata, raw_local: loc,
          raw_low: low, raw_high: high};
    access_q.push_back(a);
  endtask

  // mix of empty, full, one-hot, sparse and dense words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3, 4:    return $urandom & $urandom;
      5:       return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      a.func = FUNC_SET_EN;
    end else if (pick < 30) begin
      a.func = FUNC_CLR_EN;
    end else if (pick < 42) begin
      a.func = FUNC_RD_EN;
    end else if (pick < 66) begin
      a.func = FUNC_RD_PEND;
    end else if (pick < 94) begin
      a.func = FUNC_RD_NEXT;
    end else begin
      a.func = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
    end
    a.bank      = ($urandom_range(0, 19) == 0) ? BANK_UNMAPPED : 2'($urandom_range(0, 2));
    a.wdata     = rand_word();
    // keep local lines quiet half the time so the lower priority groups win
    a.raw_local = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(rand_word());
    a.raw_low   = rand_word();
    a.raw_high  = rand_word();
    if ($urandom_range(0, 2) == 0) begin
      a.raw_low = a.raw_low & ~SC_LOW_LINES;
    end
    if ($urandom_range(0, 2) == 0) begin
      a.raw_high = a.raw_high & ~SC_HIGH_LINES;
    end
    return a;
  endfunction

  // hold the sender until every outstanding result has come back
  task automatic drain();
    while (access_q.size() > 0 || s_axis_tvalid_i || pending_replies.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic queue_random(input int n);
    repeat (n) begin
      access_q.push_back(rand_access());
    end
  endtask

  initial begin
    loc_en_m  = '0;
    low_en_m  = '0;
    high_en_m = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing enabled yet, all lines high
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, 8'hff, '1, '1);
    push_access(FUNC_RD_EN, BANK_LOCAL, '0, '0, '0, '0);
    push_access(FUNC_RD_EN, BANK_LOW, '0, '0, '0, '0);
    push_access(FUNC_RD_EN, BANK_HIGH, '0, '0, '0, '0);
    push_access(FUNC_RD_EN, BANK_UNMAPPED, '0, '0, '0, '0);
    // enable everything; the decode of the write itself still sees old enables
    push_access(FUNC_SET_EN, BANK_LOCAL, '1, 8'hff, '1, '1);
    push_access(FUNC_SET_EN, BANK_LOW, '1, 8'hff, '1, '1);
    push_access(FUNC_SET_EN, BANK_HIGH, '1, '0, '1, '1);
    push_access(FUNC_SET_EN, BANK_UNMAPPED, '1, '0, '0, '0);
    push_access(FUNC_RD_EN, BANK_LOCAL, '0, '0, '0, '0);
    push_access(FUNC_RD_PEND, BANK_LOCAL, '0, 8'hff, '1, '1);
    push_access(FUNC_RD_PEND, BANK_LOW, '0, 8'hff, '1, '1);
    push_access(FUNC_RD_PEND, BANK_HIGH, '0, 8'hff, '1, '1);
    push_access(FUNC_RD_PEND, BANK_UNMAPPED, '0, 8'hff, '1, '1);
    // priority order: local, low shortcuts, high shortcuts, low, high
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, 8'h80, '1, '1);
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, '0, 32'h0008_0001, '1);
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, '0, 32'h0000_0001, 32'h4000_0000);
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, '0, 32'h8000_0000, 32'h0000_0001);
    push_access(FUNC_RD_NEXT, BANK_LOCAL, '0, '0, '0, 32'h8000_0000);
    // reserved functions do nothing
    push_access(FUNC_RSVD_FIRST, BANK_LOW, '1, 8'hff, '1, '1);
    push_access(FUNC_RSVD_LAST, BANK_HIGH, '1, 8'hff, '1, '1);
    // clears, upper wdata bits ignored on the local bank
    push_access(FUNC_CLR_EN, BANK_LOCAL, 32'hffff_ff0f, 8'hff, '0, '0);
    push_access(FUNC_CLR_EN, BANK_LOW, '1, 8'hff, '1, '1);
    push_access(FUNC_CLR_EN, BANK_HIGH, 32'h0000_0001, '0, '0, '1);
    push_access(FUNC_CLR_EN, BANK_UNMAPPED, '1, '0, '0, '0);
    push_access(FUNC_RD_EN, BANK_HIGH, '0, '0, '0, '0);
    push_access(FUNC_RD_PEND, BANK_LOCAL, '0, 8'hff, '1, '1);

    queue_random(220);
    drain();

    src_idle_pct  = 49;
    snk_stall_pct = 6;
    queue_random(220);
    drain();

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    queue_random(210);
    drain();

    // quiet tail: any stray result would be flagged by the monitor
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("banked_interrupt_controller_test OK");
    end else begin
      $display("banked_interrupt_controller_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_replies.size());
    $display("banked_interrupt_controller_test NOT OK");
    $finish;
  end

endmodule

// File: banked_interrupt_controller.f
hdl/bic_pkg.sv
hdl/bic_enables.sv
hdl/bic_pending.sv
hdl/banked_interrupt_controller.sv
verif/banked_interrupt_controller_test.sv
